>>> hw/rtl/scap_pkg.sv
// package for the six-channel adpcm sample player
// constants, opcodes, step table and shared types; no dependencies
`timescale 1ns / 1ps
package scap_pkg;
  localparam int NUM_CH = 6;
  localparam int ROM_DEPTH_DEF = 65536;
  localparam int POS_W = 24;
  localparam int SIG_W = 12;
  localparam int STEP_W = 6;
  localparam int MIX_W = 18;
  localparam int STEP_MAX = 48;

  localparam logic [1:0] OP_REG  = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [5:0] RA_KEY   = 6'h00;
  localparam logic [5:0] RA_TL    = 6'h01;
  localparam logic [5:0] RA_PAN   = 6'h08;
  localparam logic [5:0] RA_STH   = 6'h10;
  localparam logic [5:0] RA_STL   = 6'h18;
  localparam logic [5:0] RA_ENH   = 6'h20;
  localparam logic [5:0] RA_ENL   = 6'h28;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] reg_address;
    logic [7:0] write_data;
    logic [15:0] rom_address;
  } in_item_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_out;
    logic [NUM_CH-1:0] end_flags;
  } out_item_t;

  function automatic logic [10:0] step_size(input logic [STEP_W-1:0] i);
    logic [10:0] t [0:48];
    t = '{11'd16, 11'd17, 11'd19, 11'd21, 11'd23, 11'd25, 11'd28, 11'd31, 11'd34,
          11'd37, 11'd41, 11'd45, 11'd50, 11'd55, 11'd60, 11'd66, 11'd73, 11'd80,
          11'd88, 11'd97, 11'd107, 11'd118, 11'd130, 11'd143, 11'd157, 11'd173,
          11'd190, 11'd209, 11'd230, 11'd253, 11'd279, 11'd307, 11'd337, 11'd371,
          11'd408, 11'd449, 11'd494, 11'd544, 11'd598, 11'd658, 11'd724, 11'd796,
          11'd876, 11'd963, 11'd1060, 11'd1166, 11'd1282, 11'd1411, 11'd1552};
    if (i > 6'(STEP_MAX)) return t[STEP_MAX];
    return t[i];
  endfunction

  function automatic logic signed [4:0] step_adj(input logic [2:0] n);
    case (n)
      3'd4: return 5'sd2;
      3'd5: return 5'sd4;
      3'd6: return 5'sd6;
      3'd7: return 5'sd8;
      default: return -5'sd1;
    endcase
  endfunction
endpackage

>>> hw/rtl/scap_if.sv
// valid/ready channel interface carrying one payload
// depends on nothing; payload type given as a type parameter
`timescale 1ns / 1ps
interface scap_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/six_channel_adpcm_sample_player.sv
// six-channel 4-bit adpcm sample player, top level
// in: register write / rom load / tick / no-op transactions
// out: one transaction per input with the held mix and end flags
// a tick is walked channel by channel through one shared decode and
// one shared multiplier; the rom is one single-port ram read per channel
// a write, load or no-op passes the exec and out states to the output register;
// a tick passes exec, then per channel a check and a multiply-accumulate state,
// with a rom read and a decode state between them for a channel that plays in
// range, and then out
// a new transaction is taken as soon as the sequencer is idle; a finished
// one waits in its last state until the output register is free, so a
// stalled receiver holds one result and one finished transaction, then
// in_ready stays low
// reset (rst_n low, synchronous) clears all channel state, the mix and
// the flags, sets total level to 63; rom contents stay undefined and
// the rom length register (written through cfg_wdata) resets to zero
// depends on scap_pkg, scap_if, scap_ram, scap_decode
`timescale 1ns / 1ps
module six_channel_adpcm_sample_player import scap_pkg::*; #(
  parameter int ROM_DEPTH = ROM_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  scap_if.sink         in_ch,
  scap_if.source       out_ch,
  input  logic         cfg_we,
  input  logic [16:0]  cfg_wdata
);
  localparam int AW = $clog2(ROM_DEPTH);
  localparam int LW = AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_MAC  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r;
  in_item_t   item_r;
  logic [2:0] ch_r;
  logic [LW-1:0] len_r;

  // per-channel registers, read at the channel counter but for the start and end bytes, which key-on reads
  logic [NUM_CH-1:0] playing_r, lownib_r;
  logic [POS_W-1:0] pos_r [NUM_CH];
  logic [POS_W-1:0] endad_r [NUM_CH];
  logic [7:0] sth_r [NUM_CH], stl_r [NUM_CH], enh_r [NUM_CH], enl_r [NUM_CH];
  logic [7:0] pan_r [NUM_CH];
  logic signed [SIG_W-1:0] sig_r [NUM_CH];
  logic [STEP_W-1:0] step_r [NUM_CH];
  logic [7:0] tl_r;
  logic [NUM_CH-1:0] flags_r;
  logic [NUM_CH-1:0] out_flags_r;
  logic signed [MIX_W-1:0] mix_r, acc_r;
  logic signed [SIG_W-1:0] s_r;
  logic [5:0] vol_r;
  logic dec_r;
  logic out_valid_r;

  // rom length clipped to the depth
  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= '0;
    else if (cfg_we)
      len_r <= (32'(cfg_wdata) > ROM_DEPTH) ? LW'(ROM_DEPTH) : LW'(cfg_wdata);
  end

  // rom port: load writes, tick reads at the channel position
  logic rom_we;
  logic [AW-1:0] rom_addr;
  logic [7:0] rom_q;
  logic [POS_W-1:0] cur_pos;
  assign cur_pos = pos_r[ch_r];
  assign rom_we = (state_r == S_EXEC) && (item_r.opcode == OP_LOAD) &&
                  (32'(item_r.rom_address) < ROM_DEPTH);
  assign rom_addr = rom_we ? AW'(item_r.rom_address) : AW'(cur_pos);

  scap_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
    .clk(clk), .we(rom_we), .addr(rom_addr), .wdata(item_r.write_data), .rdata(rom_q)
  );

  logic [3:0] nib;
  logic signed [SIG_W-1:0] dec_sig;
  logic [STEP_W-1:0] dec_step;
  assign nib = lownib_r[ch_r] ? rom_q[3:0] : rom_q[7:4];
  scap_decode u_dec (
    .nib(nib), .sig_in(sig_r[ch_r]), .step_in(step_r[ch_r]),
    .sig_out(dec_sig), .step_out(dec_step)
  );

  // attenuation to volume for the current channel
  logic [6:0] att;
  assign att = 7'(tl_r[5:0]) + 7'({pan_r[ch_r][4:0], 1'b0});

  // shared multiplier on registered operands, feeding the divide and accumulate directly
  logic signed [18:0] prod;
  logic signed [18:0] scaled;
  assign prod = s_r * $signed({1'b0, vol_r});
  assign scaled = (prod < 0) ? -((-prod) >>> 3) : (prod >>> 3);

  logic pos_bad;
  logic [LW-1:0] pos_lo;
  assign pos_lo = LW'(cur_pos);
  assign pos_bad = (len_r == '0) || (cur_pos > endad_r[ch_r]) ||
                   ((POS_W > LW) && ((cur_pos >> LW) != '0)) || (pos_lo >= len_r);

  logic [POS_W-1:0] pos_inc;
  assign pos_inc = cur_pos + POS_W'(1);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data.mix_out = mix_r;
  assign out_ch.data.end_flags = out_flags_r;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) item_r <= in_ch.data;
    if (state_r == S_DEC) s_r <= dec_sig;
    if (state_r == S_DEC) vol_r <= (att > 7'd63) ? 6'd0 : 6'(7'd63 - att);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r <= '0;
      out_valid_r <= 1'b0;
      playing_r <= '0;
      lownib_r <= '0;
      tl_r <= 8'd63;
      flags_r <= '0;
      out_flags_r <= '0;
      mix_r <= '0;
      acc_r <= '0;
      dec_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        pos_r[i] <= '0; endad_r[i] <= '0;
        sth_r[i] <= '0; stl_r[i] <= '0; enh_r[i] <= '0; enl_r[i] <= '0;
        pan_r[i] <= '0; sig_r[i] <= '0; step_r[i] <= '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (item_r.opcode == OP_TICK) begin
            ch_r <= '0;
            acc_r <= '0;
            state_r <= S_CHK;
          end else begin
            if (item_r.opcode == OP_REG) begin
              if (item_r.reg_address == RA_KEY) begin
                for (int i = 0; i < NUM_CH; i++) begin
                  if (item_r.write_data[i]) begin
                    if (item_r.write_data[7]) playing_r[i] <= 1'b0;
                    else begin
                      pos_r[i] <= {sth_r[i], stl_r[i], 8'h00};
                      endad_r[i] <= {enh_r[i], enl_r[i], 8'h00};
                      lownib_r[i] <= 1'b0;
                      playing_r[i] <= 1'b1;
                    end
                    sig_r[i] <= '0;
                    step_r[i] <= '0;
                    flags_r[i] <= 1'b0;
                  end
                end
              end else if (item_r.reg_address == RA_TL) tl_r <= item_r.write_data;
              else begin
                for (int i = 0; i < NUM_CH; i++) begin
                  if (item_r.reg_address == RA_PAN + 6'(i)) pan_r[i] <= item_r.write_data;
                  if (item_r.reg_address == RA_STH + 6'(i)) sth_r[i] <= item_r.write_data;
                  if (item_r.reg_address == RA_STL + 6'(i)) stl_r[i] <= item_r.write_data;
                  if (item_r.reg_address == RA_ENH + 6'(i)) enh_r[i] <= item_r.write_data;
                  if (item_r.reg_address == RA_ENL + 6'(i)) enl_r[i] <= item_r.write_data;
                end
              end
            end
            state_r <= S_OUT;
          end
        end
        S_CHK: begin
          // stopped channels are skipped, out-of-range ones end here
          dec_r <= 1'b0;
          if (!playing_r[ch_r]) state_r <= S_MAC;
          else if (pos_bad) begin
            playing_r[ch_r] <= 1'b0;
            flags_r[ch_r] <= 1'b1;
            state_r <= S_MAC;
          end else state_r <= S_RD;
        end
        S_RD: state_r <= S_DEC;
        S_DEC: begin
          sig_r[ch_r] <= dec_sig;
          step_r[ch_r] <= dec_step;
          lownib_r[ch_r] <= !lownib_r[ch_r];
          dec_r <= 1'b1;
          if (lownib_r[ch_r]) begin
            pos_r[ch_r] <= pos_inc;
            if (pos_inc > endad_r[ch_r]) begin
              playing_r[ch_r] <= 1'b0;
              flags_r[ch_r] <= 1'b1;
            end
          end
          state_r <= S_MAC;
        end
        S_MAC: begin
          // only decoded channels with output enabled add in
          if (dec_r && pan_r[ch_r][7:6] != 2'b00)
            acc_r <= acc_r + MIX_W'(scaled);
          if (ch_r == 3'(NUM_CH - 1)) state_r <= S_OUT;
          else begin
            ch_r <= ch_r + 3'd1;
            state_r <= S_CHK;
          end
        end
        S_OUT: begin
          // hold here while the previous result still waits
          if (!out_valid_r || out_ch.ready) begin
            if (item_r.opcode == OP_TICK) mix_r <= acc_r;
            out_flags_r <= flags_r;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> out_valid_r) else $error("result not raised");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_r < 3'(NUM_CH))) else $error("channel counter out of range");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC) |-> (dec_step <= 6'(STEP_MAX))) else $error("step out of range");
`endif
endmodule

>>> hw/rtl/scap_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module scap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/scap_decode.sv
// adpcm nibble decode step: signal and step index update, both clamped
// depends on scap_pkg
`timescale 1ns / 1ps
module scap_decode import scap_pkg::*; (
  input  logic [3:0]               nib,
  input  logic signed [SIG_W-1:0]  sig_in,
  input  logic [STEP_W-1:0]        step_in,
  output logic signed [SIG_W-1:0]  sig_out,
  output logic [STEP_W-1:0]        step_out
);
  logic [10:0] sv;
  logic [12:0] d;
  logic signed [13:0] s;
  logic signed [7:0] st;
  always_comb begin
    sv = step_size(step_in);
    d = 13'(sv >> 3);
    if (nib[2]) d = d + 13'(sv);
    if (nib[1]) d = d + 13'(sv >> 1);
    if (nib[0]) d = d + 13'(sv >> 2);
    s = 14'(sig_in) + (nib[3] ? -$signed({1'b0, d}) : $signed({1'b0, d}));
    if (s > 14'sd2047) sig_out = 12'sd2047;
    else if (s < -14'sd2048) sig_out = -12'sd2048;
    else sig_out = s[SIG_W-1:0];
    st = $signed({2'b00, step_in}) + 8'(step_adj(nib[2:0]));
    if (st > 8'sd48) step_out = 6'(STEP_MAX);
    else if (st < 8'sd0) step_out = '0;
    else step_out = st[STEP_W-1:0];
  end
endmodule
